[sv/sqpg_pkg.sv]
// sqpg_pkg: shared types, rule codes and Q2.30 coefficient tables for the
// simplex quadrature point generator
// depends on nothing
package sqpg_pkg;

	localparam int COORD_W   = 32;
	localparam int MEAS_W    = COORD_W - 1;
	localparam int FRAC_BITS = 30;
	localparam int PROD_W    = 2 * COORD_W;
	localparam int PAIR_W    = PROD_W + 1;
	localparam int ACC_W     = PROD_W + 3;
	localparam int IDX_W     = 4;
	localparam int ROW_W     = 6;
	localparam int AXIS_W    = 2;
	localparam int QDEPTH    = 2;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	typedef enum logic [2:0] {
		RULE_EDGE2 = 3'd0,
		RULE_EDGE3 = 3'd1,
		RULE_TRI3  = 3'd2,
		RULE_TRI4  = 3'd3,
		RULE_TRI7  = 3'd4,
		RULE_TET4  = 3'd5,
		RULE_TET5  = 3'd6,
		RULE_TET15 = 3'd7
	} rule_t;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t              va;
		coord_t              vb;
		coord_t              vc;
		coord_t              vd;
		logic [MEAS_W-1:0]   meas;
	} data_t;

	typedef struct packed {
		logic [AXIS_W-1:0]   axis;
		data_t               data;
		logic [ROW_W-1:0]    first;
		logic [IDX_W-1:0]    last_idx;
	} item_t;

	typedef struct packed {
		logic                valid;
		logic [IDX_W-1:0]    index;
		logic [AXIS_W-1:0]   axis;
		logic                last;
	} ctl_t;

	typedef struct packed {
		coord_t ca;
		coord_t cb;
		coord_t cc;
		coord_t cd;
		coord_t cw;
	} coef_row_t;

	// barycentric and weight coefficients, signed Q2.30
	localparam coord_t Q_HALF    = 32'sd536870912;
	localparam coord_t Q_THIRD   = 32'sd357913941;
	localparam coord_t Q_SIXTH   = 32'sd178956971;
	localparam coord_t Q_QUARTER = 32'sd268435456;
	localparam coord_t Q_FIFTH   = 32'sd214748365;
	localparam coord_t Q_3FIFTH  = 32'sd644245094;
	localparam coord_t E2_HI     = 32'sd846833478;
	localparam coord_t E2_LO     = 32'sd226908346;
	localparam coord_t E3_HI     = 32'sd952729332;
	localparam coord_t E3_LO     = 32'sd121012492;
	localparam coord_t T7_A      = 32'sd108755559;
	localparam coord_t T7_A1     = 32'sd856230706;
	localparam coord_t T7_B      = 32'sd504811197;
	localparam coord_t T7_B1     = 32'sd64119429;
	localparam coord_t K4_A      = 32'sd148387471;
	localparam coord_t K4_A1     = 32'sd628579412;
	localparam coord_t K15_A     = 32'sd98751927;
	localparam coord_t K15_A1    = 32'sd777486043;
	localparam coord_t K15_B     = 32'sd343377059;
	localparam coord_t K15_B1    = 32'sd43610646;
	localparam coord_t K15_C     = 32'sd60506246;
	localparam coord_t K15_C1    = 32'sd476364666;
	localparam coord_t W_E3_MID  = 32'sd477218588;
	localparam coord_t W_E3_SIDE = 32'sd298261618;
	localparam coord_t W_T4_MID  = -32'sd603979776;
	localparam coord_t W_T4_SIDE = 32'sd559240533;
	localparam coord_t W_T7_MID  = 32'sd241591910;
	localparam coord_t W_T7_A    = 32'sd135226165;
	localparam coord_t W_T7_B    = 32'sd142157139;
	localparam coord_t W_K5_SIDE = 32'sd483183821;
	localparam coord_t W_K5_MID  = -32'sd858993459;
	localparam coord_t W_K15_A   = 32'sd77241856;
	localparam coord_t W_K15_B   = 32'sd74161423;
	localparam coord_t W_K15_C   = 32'sd56811737;
	localparam coord_t W_K15_MID = 32'sd127258290;
	localparam coord_t Q_ZERO    = 32'sd0;

	localparam coord_t SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam coord_t SAT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	function automatic coef_row_t mk(coord_t a, coord_t b, coord_t c, coord_t d, coord_t w);
		coef_row_t r;
		r.ca = a;
		r.cb = b;
		r.cc = c;
		r.cd = d;
		r.cw = w;
		return r;
	endfunction

	// first table row of each rule
	function automatic logic [ROW_W-1:0] rule_first(rule_t rule);
		logic [ROW_W-1:0] f;
		case (rule)
			RULE_EDGE2: f = 6'd0;
			RULE_EDGE3: f = 6'd2;
			RULE_TRI3:  f = 6'd5;
			RULE_TRI4:  f = 6'd8;
			RULE_TRI7:  f = 6'd12;
			RULE_TET4:  f = 6'd19;
			RULE_TET5:  f = 6'd23;
			RULE_TET15: f = 6'd28;
			default:    f = 6'd0;
		endcase
		return f;
	endfunction

	// index of the final point of each rule
	function automatic logic [IDX_W-1:0] rule_last(rule_t rule);
		logic [IDX_W-1:0] n;
		case (rule)
			RULE_EDGE2: n = 4'd1;
			RULE_EDGE3: n = 4'd2;
			RULE_TRI3:  n = 4'd2;
			RULE_TRI4:  n = 4'd3;
			RULE_TRI7:  n = 4'd6;
			RULE_TET4:  n = 4'd3;
			RULE_TET5:  n = 4'd4;
			RULE_TET15: n = 4'd14;
			default:    n = 4'd1;
		endcase
		return n;
	endfunction

	function automatic coef_row_t coef_row(logic [ROW_W-1:0] row);
		coef_row_t r;
		case (row)
			6'd0:  r = mk(E2_LO, E2_HI, Q_ZERO, Q_ZERO, Q_HALF);
			6'd1:  r = mk(E2_HI, E2_LO, Q_ZERO, Q_ZERO, Q_HALF);
			6'd2:  r = mk(Q_HALF, Q_HALF, Q_ZERO, Q_ZERO, W_E3_MID);
			6'd3:  r = mk(E3_HI, E3_LO, Q_ZERO, Q_ZERO, W_E3_SIDE);
			6'd4:  r = mk(E3_LO, E3_HI, Q_ZERO, Q_ZERO, W_E3_SIDE);
			6'd5:  r = mk(Q_HALF, Q_HALF, Q_ZERO, Q_ZERO, Q_THIRD);
			6'd6:  r = mk(Q_HALF, Q_ZERO, Q_HALF, Q_ZERO, Q_THIRD);
			6'd7:  r = mk(Q_ZERO, Q_HALF, Q_HALF, Q_ZERO, Q_THIRD);
			6'd8:  r = mk(Q_THIRD, Q_THIRD, Q_THIRD, Q_ZERO, W_T4_MID);
			6'd9:  r = mk(Q_FIFTH, Q_FIFTH, Q_3FIFTH, Q_ZERO, W_T4_SIDE);
			6'd10: r = mk(Q_FIFTH, Q_3FIFTH, Q_FIFTH, Q_ZERO, W_T4_SIDE);
			6'd11: r = mk(Q_3FIFTH, Q_FIFTH, Q_FIFTH, Q_ZERO, W_T4_SIDE);
			6'd12: r = mk(Q_THIRD, Q_THIRD, Q_THIRD, Q_ZERO, W_T7_MID);
			6'd13: r = mk(T7_A, T7_A, T7_A1, Q_ZERO, W_T7_A);
			6'd14: r = mk(T7_A, T7_A1, T7_A, Q_ZERO, W_T7_A);
			6'd15: r = mk(T7_A1, T7_A, T7_A, Q_ZERO, W_T7_A);
			6'd16: r = mk(T7_B, T7_B, T7_B1, Q_ZERO, W_T7_B);
			6'd17: r = mk(T7_B, T7_B1, T7_B, Q_ZERO, W_T7_B);
			6'd18: r = mk(T7_B1, T7_B, T7_B, Q_ZERO, W_T7_B);
			6'd19: r = mk(K4_A, K4_A, K4_A, K4_A1, Q_QUARTER);
			6'd20: r = mk(K4_A1, K4_A, K4_A, K4_A, Q_QUARTER);
			6'd21: r = mk(K4_A, K4_A1, K4_A, K4_A, Q_QUARTER);
			6'd22: r = mk(K4_A, K4_A, K4_A1, K4_A, Q_QUARTER);
			6'd23: r = mk(Q_SIXTH, Q_SIXTH, Q_SIXTH, Q_HALF, W_K5_SIDE);
			6'd24: r = mk(Q_HALF, Q_SIXTH, Q_SIXTH, Q_SIXTH, W_K5_SIDE);
			6'd25: r = mk(Q_SIXTH, Q_HALF, Q_SIXTH, Q_SIXTH, W_K5_SIDE);
			6'd26: r = mk(Q_SIXTH, Q_SIXTH, Q_HALF, Q_SIXTH, W_K5_SIDE);
			6'd27: r = mk(Q_QUARTER, Q_QUARTER, Q_QUARTER, Q_QUARTER, W_K5_MID);
			6'd28: r = mk(K15_A, K15_A, K15_A, K15_A1, W_K15_A);
			6'd29: r = mk(K15_A, K15_A, K15_A1, K15_A, W_K15_A);
			6'd30: r = mk(K15_A, K15_A1, K15_A, K15_A, W_K15_A);
			6'd31: r = mk(K15_A1, K15_A, K15_A, K15_A, W_K15_A);
			6'd32: r = mk(K15_B, K15_B, K15_B, K15_B1, W_K15_B);
			6'd33: r = mk(K15_B, K15_B, K15_B1, K15_B, W_K15_B);
			6'd34: r = mk(K15_B, K15_B1, K15_B, K15_B, W_K15_B);
			6'd35: r = mk(K15_B1, K15_B, K15_B, K15_B, W_K15_B);
			6'd36: r = mk(K15_C, K15_C, K15_C1, K15_C1, W_K15_C);
			6'd37: r = mk(K15_C, K15_C1, K15_C1, K15_C, W_K15_C);
			6'd38: r = mk(K15_C, K15_C1, K15_C, K15_C1, W_K15_C);
			6'd39: r = mk(K15_C1, K15_C, K15_C, K15_C1, W_K15_C);
			6'd40: r = mk(K15_C1, K15_C1, K15_C, K15_C, W_K15_C);
			6'd41: r = mk(K15_C1, K15_C, K15_C1, K15_C, W_K15_C);
			6'd42: r = mk(Q_QUARTER, Q_QUARTER, Q_QUARTER, Q_QUARTER, W_K15_MID);
			default: r = mk(Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO);
		endcase
		return r;
	endfunction

	// round to nearest (ties up), drop the fraction bits, saturate
	function automatic coord_t round_sat(logic signed [ACC_W-1:0] x);
		logic signed [ACC_W-1:0]           t;
		logic signed [ACC_W-FRAC_BITS-1:0] sh;
		coord_t                            r;
		t  = x + (ACC_W'(1) <<< (FRAC_BITS - 1));
		sh = t[ACC_W-1:FRAC_BITS];
		if (sh[ACC_W-FRAC_BITS-1:COORD_W-1] != {(ACC_W-FRAC_BITS-COORD_W+1){sh[COORD_W-1]}})
			r = sh[ACC_W-FRAC_BITS-1] ? SAT_MIN : SAT_MAX;
		else
			r = sh[COORD_W-1:0];
		return r;
	endfunction

endpackage

[sv/sqpg_front.sv]
// sqpg_front: input acceptance, rule register, per-item classification and
// the short item queue toward the back end; depends on sqpg_pkg
module sqpg_front
	import sqpg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [AXIS_W-1:0]     in_axis,
	input  data_t                 in_data,
	output logic                  q_valid,
	output item_t                 q_item,
	input  logic                  pop
);

	rule_t              rule_q;
	item_t              ent_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               push;
	item_t              new_item;

	assign in_ready = (count_q != QCNT_W'(QDEPTH));
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != '0);
	assign q_item   = ent_q[rd_ptr_q];

	// classify: rule fixes the table window and point count
	always_comb begin
		new_item.axis     = in_axis;
		new_item.data     = in_data;
		new_item.first    = rule_first(rule_q);
		new_item.last_idx = rule_last(rule_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_q <= RULE_EDGE2;
		end else if (cfg_we) begin
			rule_q <= rule_t'(cfg_wdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= new_item;
	end

	a_pop_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("pop from empty queue");

	a_fill_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue fill count lost a request");

endmodule

[sv/sqpg_seq.sv]
// sqpg_seq: back-end sequencer, walks the points of the head item and looks
// up the coefficient row of each; depends on sqpg_pkg
module sqpg_seq
	import sqpg_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  item_t      q_item,
	input  logic       en,
	output logic       pop,
	output ctl_t       ctl_s1,
	output coef_row_t  coef_s1,
	output data_t      data_s1
);

	logic [IDX_W-1:0] cnt_q;
	logic             is_last;
	logic [ROW_W-1:0] row;

	assign is_last = (cnt_q == q_item.last_idx);
	assign row     = q_item.first + ROW_W'(cnt_q);
	assign pop     = en && q_valid && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1.valid <= q_valid;
			ctl_s1.index <= cnt_q;
			ctl_s1.axis  <= q_item.axis;
			ctl_s1.last  <= is_last;
			if (q_valid)
				cnt_q <= is_last ? '0 : cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			coef_s1      <= coef_row(row);
			data_s1      <= q_item.data;
		end
	end

	a_cnt_in_rule: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid |-> cnt_q <= q_item.last_idx)
		else $error("point counter ran past the rule");

	a_pop_marks_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> ctl_s1.valid && ctl_s1.last)
		else $error("item retired without a last point");

endmodule

[sv/sqpg_calc.sv]
// sqpg_calc: multiply, sum, round and saturate pipeline with the result
// register; depends on sqpg_pkg
module sqpg_calc
	import sqpg_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  ctl_t              ctl_s1,
	input  coef_row_t         coef_s1,
	input  data_t             data_s1,
	output logic              en,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [IDX_W-1:0]  out_index,
	output logic [AXIS_W-1:0] out_axis,
	output coord_t            out_coord,
	output coord_t            out_weight,
	output logic              out_last
);

	ctl_t                     ctl_s2;
	ctl_t                     ctl_s3;
	ctl_t                     res_q;
	logic signed [PROD_W-1:0] pa_s2, pb_s2, pc_s2, pd_s2, pw_s2;
	logic signed [PAIR_W-1:0] pab_s3, pcd_s3;
	logic signed [PROD_W-1:0] pw_s3;
	coord_t                   coord_q;
	coord_t                   weight_q;
	logic signed [ACC_W-1:0]  acc;
	logic signed [ACC_W-1:0]  wacc;
	coord_t                   meas_s;

	// whole back end advances when the result register can take a point
	assign en = !res_q.valid || out_ready;

	assign meas_s = $signed({1'b0, data_s1.meas});
	assign acc    = ACC_W'(pab_s3) + ACC_W'(pcd_s3);
	assign wacc   = ACC_W'(pw_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			res_q  <= '0;
		end else if (en) begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			res_q  <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s2 <= $signed(data_s1.va) * $signed(coef_s1.ca);
			pb_s2 <= $signed(data_s1.vb) * $signed(coef_s1.cb);
			pc_s2 <= $signed(data_s1.vc) * $signed(coef_s1.cc);
			pd_s2 <= $signed(data_s1.vd) * $signed(coef_s1.cd);
			pw_s2 <= meas_s * $signed(coef_s1.cw);

			pab_s3 <= PAIR_W'(pa_s2) + PAIR_W'(pb_s2);
			pcd_s3 <= PAIR_W'(pc_s2) + PAIR_W'(pd_s2);
			pw_s3  <= pw_s2;

			coord_q     <= round_sat(acc);
			weight_q    <= round_sat(wacc);
		end
	end

	assign out_valid  = res_q.valid;
	assign out_index  = res_q.index;
	assign out_axis   = res_q.axis;
	assign out_last   = res_q.last;
	assign out_coord  = coord_q;
	assign out_weight = weight_q;

	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(ctl_s3.valid) && $stable(ctl_s2.valid) && $stable(ctl_s3.index))
		else $error("pipeline moved during a stall");

endmodule

[sv/simplex_quadrature_point_generator.sv]
// simplex_quadrature_point_generator: top level, joins the front end
// (rule register, classify, queue) to the sequencer and arithmetic pipeline
// depends on sqpg_pkg, sqpg_front, sqpg_seq, sqpg_calc
//
// channel   direction  handshake                      payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tdata: vertices, measure; tuser: axis
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata: index, coord, weight; tuser: axis
// cfg       in         cfg_we (always taken)          cfg_wdata: rule_select
//
// one input item gives 2 to 15 result points, one per cycle unless stalled:
// the sequencer issues one coefficient row per cycle, so an item holds the
// back end for one row per point (15 for the tetrahedron 15 rule)
// first point passes queue, s1, s2, s3 and result register in that order
// reset sets the rule to two point edge and empties the two entry queue
// m_axis_tready low with a point waiting freezes the whole back end; the
// front keeps accepting requests until the queue is full
module simplex_quadrature_point_generator
	import sqpg_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	// configuration: rule_select[2:0]
	input  logic         cfg_we,
	input  logic [2:0]   cfg_wdata,
	// input requests
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [159:0] s_axis_tdata,  // vertex_a[31:0] vertex_b[63:32] vertex_c[95:64]
	                                    // vertex_d[127:96] measure[158:128] zero[159]
	input  logic [1:0]   s_axis_tuser,  // axis[1:0]
	// result points
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [71:0]  m_axis_tdata,  // point_index[3:0] point_coord[35:4]
	                                    // point_weight[67:36] zero[71:68]
	output logic [1:0]   m_axis_tuser,  // axis_out[1:0]
	output logic         m_axis_tlast   // last point of the rule
);

	data_t             in_data;
	logic              q_valid;
	item_t             q_item;
	logic              pop;
	logic              en;
	ctl_t              ctl_s1;
	coef_row_t         coef_s1;
	data_t             data_s1;
	logic [IDX_W-1:0]  point_index;
	coord_t            point_coord;
	coord_t            point_weight;

	// unpack the request payload
	assign in_data.va   = s_axis_tdata[31:0];
	assign in_data.vb   = s_axis_tdata[63:32];
	assign in_data.vc   = s_axis_tdata[95:64];
	assign in_data.vd   = s_axis_tdata[127:96];
	assign in_data.meas = s_axis_tdata[158:128];

	// front: rule register, classify, queue
	sqpg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_axis   (s_axis_tuser),
		.in_data   (in_data),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.pop       (pop)
	);

	// back: point sequencer with table lookup
	sqpg_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_item),
		.en      (en),
		.pop     (pop),
		.ctl_s1  (ctl_s1),
		.coef_s1 (coef_s1),
		.data_s1 (data_s1)
	);

	// back: products, sums, rounding, saturation, result register
	sqpg_calc u_calc (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl_s1     (ctl_s1),
		.coef_s1    (coef_s1),
		.data_s1    (data_s1),
		.en         (en),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_index  (point_index),
		.out_axis   (m_axis_tuser),
		.out_coord  (point_coord),
		.out_weight (point_weight),
		.out_last   (m_axis_tlast)
	);

	// pack the result payload
	assign m_axis_tdata = {4'b0000, point_weight, point_coord, point_index};

endmodule

[tb/tb.sv]
// tb: self-checking bench for simplex_quadrature_point_generator
// predicts every gauss point of every request and checks the result stream
// depends on sqpg_pkg and the generator rtl
module tb;
	import sqpg_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;

	// point and weight coefficients, signed q2.30
	localparam int HALF   = 536870912;
	localparam int THIRD  = 357913941;
	localparam int SIXTH  = 178956971;
	localparam int QUART  = 268435456;
	localparam int FIFTH  = 214748365;
	localparam int FIFTH3 = 644245094;
	localparam int E2H    = 846833478;
	localparam int E2L    = 226908346;
	localparam int E3H    = 952729332;
	localparam int E3L    = 121012492;
	localparam int T7A    = 108755559;
	localparam int T7A1   = 856230706;
	localparam int T7B    = 504811197;
	localparam int T7B1   = 64119429;
	localparam int K4A    = 148387471;
	localparam int K4A1   = 628579412;
	localparam int KA     = 98751927;
	localparam int KA1    = 777486043;
	localparam int KB     = 343377059;
	localparam int KB1    = 43610646;
	localparam int KC     = 60506246;
	localparam int KC1    = 476364666;
	localparam int WE3M   = 477218588;
	localparam int WE3S   = 298261618;
	localparam int WT4M   = -603979776;
	localparam int WT4S   = 559240533;
	localparam int WT7M   = 241591910;
	localparam int WT7A   = 135226165;
	localparam int WT7B   = 142157139;
	localparam int WK5S   = 483183821;
	localparam int WK5M   = -858993459;
	localparam int WKA    = 77241856;
	localparam int WKB    = 74161423;
	localparam int WKC    = 56811737;
	localparam int WKM    = 127258290;

	// one row per gauss point: vertex a, b, c, d coefficients, then weight
	localparam int PT_COEF [43][5] = '{
		'{E2L, E2H, 0, 0, HALF}, '{E2H, E2L, 0, 0, HALF},
		'{HALF, HALF, 0, 0, WE3M}, '{E3H, E3L, 0, 0, WE3S}, '{E3L, E3H, 0, 0, WE3S},
		'{HALF, HALF, 0, 0, THIRD}, '{HALF, 0, HALF, 0, THIRD}, '{0, HALF, HALF, 0, THIRD},
		'{THIRD, THIRD, THIRD, 0, WT4M}, '{FIFTH, FIFTH, FIFTH3, 0, WT4S},
		'{FIFTH, FIFTH3, FIFTH, 0, WT4S}, '{FIFTH3, FIFTH, FIFTH, 0, WT4S},
		'{THIRD, THIRD, THIRD, 0, WT7M},
		'{T7A, T7A, T7A1, 0, WT7A}, '{T7A, T7A1, T7A, 0, WT7A}, '{T7A1, T7A, T7A, 0, WT7A},
		'{T7B, T7B, T7B1, 0, WT7B}, '{T7B, T7B1, T7B, 0, WT7B}, '{T7B1, T7B, T7B, 0, WT7B},
		'{K4A, K4A, K4A, K4A1, QUART}, '{K4A1, K4A, K4A, K4A, QUART},
		'{K4A, K4A1, K4A, K4A, QUART}, '{K4A, K4A, K4A1, K4A, QUART},
		'{SIXTH, SIXTH, SIXTH, HALF, WK5S}, '{HALF, SIXTH, SIXTH, SIXTH, WK5S},
		'{SIXTH, HALF, SIXTH, SIXTH, WK5S}, '{SIXTH, SIXTH, HALF, SIXTH, WK5S},
		'{QUART, QUART, QUART, QUART, WK5M},
		'{KA, KA, KA, KA1, WKA}, '{KA, KA, KA1, KA, WKA},
		'{KA, KA1, KA, KA, WKA}, '{KA1, KA, KA, KA, WKA},
		'{KB, KB, KB, KB1, WKB}, '{KB, KB, KB1, KB, WKB},
		'{KB, KB1, KB, KB, WKB}, '{KB1, KB, KB, KB, WKB},
		'{KC, KC, KC1, KC1, WKC}, '{KC, KC1, KC1, KC, WKC}, '{KC, KC1, KC, KC1, WKC},
		'{KC1, KC, KC, KC1, WKC}, '{KC1, KC1, KC, KC, WKC}, '{KC1, KC, KC1, KC, WKC},
		'{QUART, QUART, QUART, QUART, WKM}
	};
	// first row and number of points of each rule, by rule code
	localparam int RULE_BASE [8] = '{0, 2, 5, 8, 12, 19, 23, 28};
	localparam int RULE_SIZE [8] = '{2, 3, 3, 4, 7, 4, 5, 15};

	typedef struct {
		logic [3:0]         idx;
		logic [1:0]         axis;
		logic signed [31:0] coord;
		logic signed [31:0] weight;
		logic               last;
	} point_t;

	// expected gauss points of accepted requests, oldest first
	class point_checker;
		rule_t  rule_sel = RULE_EDGE2;
		point_t pending[$];
		int     mismatches;
		int     requests_seen;
		int     points_seen;
		int     rule_requests[8];

		// q30 sum of products to q16.16: nearest, ties up, then clamp to 32 bits
		function logic signed [31:0] round_q30(logic signed [79:0] acc);
			logic signed [79:0] t;
			t = (acc + (80'sd1 <<< 29)) >>> 30;
			if (t > 80'sd2147483647)
				return 32'sh7fffffff;
			if (t < -80'sd2147483648)
				return 32'sh80000000;
			return t[31:0];
		endfunction

		// expand one request into the points of the current rule
		function void note_request(logic [159:0] data, logic [1:0] ax);
			logic signed [79:0] acc;
			logic signed [79:0] wacc;
			point_t             p;
			int                 base;
			int                 count;
			base  = RULE_BASE[int'(rule_sel)];
			count = RULE_SIZE[int'(rule_sel)];
			requests_seen++;
			rule_requests[int'(rule_sel)]++;
			for (int i = 0; i < count; i++) begin
				acc = '0;
				for (int j = 0; j < 4; j++)
					acc += 80'(signed'(data[32*j +: 32])) * 80'(PT_COEF[base+i][j]);
				wacc = 80'(signed'({1'b0, data[158:128]})) * 80'(PT_COEF[base+i][4]);
				p.idx    = 4'(i);
				p.axis   = ax;
				p.coord  = round_q30(acc);
				p.weight = round_q30(wacc);
				p.last   = (i == count - 1);
				pending.push_back(p);
			end
		endfunction

		function void compare(string field, longint exp_v, longint act_v);
			if (exp_v != act_v) begin
				$error("%s: expected %0d, got %0d", field, exp_v, act_v);
				mismatches++;
			end
		endfunction

		function void check_point(logic [71:0] data, logic [1:0] ax, logic last);
			point_t e;
			points_seen++;
			if (pending.size() == 0) begin
				$error("point_index: expected no point, got %0d", data[3:0]);
				mismatches++;
				return;
			end
			e = pending.pop_front();
			compare("point_index", e.idx, data[3:0]);
			compare("axis_out", e.axis, ax);
			compare("point_coord", e.coord, signed'(data[35:4]));
			compare("point_weight", e.weight, signed'(data[67:36]));
			compare("last", e.last, last);
		endfunction
	endclass

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic [2:0]   cfg_wdata = '0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [159:0] s_axis_tdata = '0;
	logic [1:0]   s_axis_tuser = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [71:0]  m_axis_tdata;
	logic [1:0]   m_axis_tuser;
	logic         m_axis_tlast;

	point_checker sb = new;
	int           send_idle_pct;
	int           stall_pct;
	int           cycle_count;

	simplex_quadrature_point_generator i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #5 clk = ~clk;

	// watchdog: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$error("no progress after %0d cycles, %0d points outstanding",
				CYCLE_LIMIT, sb.pending.size());
			$display("Verification failed");
			$finish;
		end
	end

	// result side backpressure, redrawn every cycle
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	// every accepted point goes straight to the checker
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_point(m_axis_tdata, m_axis_tuser, m_axis_tlast);
	end

	// idle mix: 0 none, 1 sender gaps, 2 receiver stalls, 3 light both
	task automatic set_pressure(int mode);
		case (mode)
			0: begin
				send_idle_pct = 0;
				stall_pct     = 0;
			end
			1: begin
				send_idle_pct = 78;
				stall_pct     = 0;
			end
			2: begin
				send_idle_pct = 0;
				stall_pct     = 78;
			end
			default: begin
				send_idle_pct = 10;
				stall_pct     = 10;
			end
		endcase
	endtask

	// one request; tvalid stays high into the next call when no gap is drawn
	task automatic send_request(logic [1:0] ax, logic [31:0] va, logic [31:0] vb,
		logic [31:0] vc, logic [31:0] vd, logic [30:0] meas);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {1'b0, meas, vd, vc, vb, va};
		s_axis_tuser  <= ax;
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_request({1'b0, meas, vd, vc, vb, va}, ax);
	endtask

	// stop sending and let every expected point come out
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// rule changes only with the pipeline empty
	task automatic write_rule(rule_t r);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= r;
		@(posedge clk);
		cfg_we      <= 1'b0;
		sb.rule_sel = r;
	endtask

	// coordinates: full range, near zero, near the ends, mid sized
	function automatic logic [31:0] rand_coord();
		logic [31:0] v;
		case ($urandom_range(3))
			0: v = $urandom;
			1: v = 32'($urandom_range(32'h3ffff)) - 32'h20000;
			2: v = $urandom_range(1) ? 32'h7fffffff - $urandom_range(255)
			                         : 32'h80000000 + $urandom_range(255);
			default: v = 32'($signed($urandom) >>> $urandom_range(16, 4));
		endcase
		return v;
	endfunction

	function automatic logic [30:0] rand_meas();
		logic [30:0] m;
		case ($urandom_range(3))
			0: m = 31'($urandom);
			1: m = 31'($urandom_range(32'h3ffff));
			2: m = 31'h7fffffff - 31'($urandom_range(255));
			default: m = 31'($urandom >> $urandom_range(20, 5));
		endcase
		return m;
	endfunction

	initial begin
		rule_t r;
		set_pressure(0);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: each rule (edge two from its reset value) sees all-max
		// inputs, all-min inputs with zero measure on the unused axis code 3,
		// and mixed signs with extreme values on vertices the rule may ignore
		for (int k = 0; k < 8; k++) begin
			if (k != 0)
				write_rule(rule_t'(k));
			send_request(2'd0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
				31'h7fffffff);
			send_request(2'd3, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
				31'h0);
			send_request(2'(1 + k % 2), 32'h00010000, 32'hfffe0000, 32'h7fffffff,
				32'h80000000, 31'h00010000);
		end

		// random: 16 phases of 30 requests, all rules first, then random rules,
		// cycling through the idle mixes
		for (int ph = 0; ph < 16; ph++) begin
			r = (ph < 8) ? rule_t'(7 - ph) : rule_t'($urandom_range(7));
			write_rule(r);
			set_pressure(ph % 4);
			for (int n = 0; n < 30; n++)
				send_request(2'($urandom_range(3)), rand_coord(), rand_coord(),
					rand_coord(), rand_coord(), rand_meas());
		end
		drain();
		repeat (20) @(posedge clk);

		$display("%0d requests over all eight rules, %0d points checked, %0d mismatches",
			sb.requests_seen, sb.points_seen, sb.mismatches);
		$display("requests per rule: %0d %0d %0d %0d %0d %0d %0d %0d",
			sb.rule_requests[0], sb.rule_requests[1], sb.rule_requests[2],
			sb.rule_requests[3], sb.rule_requests[4], sb.rule_requests[5],
			sb.rule_requests[6], sb.rule_requests[7]);
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("Verification passed");
		end else begin
			if (sb.pending.size() != 0)
				$error("%0d expected points never arrived", sb.pending.size());
			$display("Verification failed");
		end
		$finish;
	end

endmodule

[files.f]
sv/sqpg_pkg.sv
sv/sqpg_front.sv
sv/sqpg_seq.sv
sv/sqpg_calc.sv
sv/simplex_quadrature_point_generator.sv
tb/tb.sv
